// ----- src/scpa_pkg.sv -----
// Shared types and constants of the size-class pool allocator.
package scpa_pkg;

   // Field widths
   localparam int ADDR_W    = 36;
   localparam int SIZE_W    = 32;
   localparam int STAT_W    = 2;
   localparam int CLS_W     = 4;
   localparam int CSR_IDX_W = 2;

   // Defaults of the top-level parameters
   localparam int DEF_NUM_CLASSES     = 12;
   localparam int DEF_BLOCKS_PER_GROW = 64;
   localparam int DEF_STACK_DEPTH     = 1024;
   localparam int DEF_HEADER_BYTES    = 16;

   // Address map
   localparam int STRIDE_SHIFT    = 28;          // class regions 0x10000000 apart
   localparam int MIN_BLOCK_SHIFT = 6;           // class 0 block is 64 bytes
   localparam int PAGE_SHIFT      = 12;          // large requests round to 4096
   localparam int SMALL_BYTES     = 128 * 1024;  // largest small block
   localparam int MAX_SIZE_CLASS  = 15;          // top of the size search

   localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 36'h400000000;
   localparam logic [ADDR_W-1:0] LARGE_BASE_RST  = 36'h04C000000;
   localparam logic [ADDR_W-1:0] LARGE_LIMIT_RST = 36'hFFFFFFFFF;

   localparam logic [CLS_W-1:0] LARGE_CLASS = 4'd12;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_OOM,
      STAT_BAD_ADDR,
      STAT_OVERFLOW
   } status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMALL_BASE,
      CSR_LARGE_BASE,
      CSR_LARGE_LIMIT
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_READ,
      S_CARVE,
      S_CFIN
   } state_type;

   // What the evaluated request needs
   typedef enum logic [1:0] {
      ACT_RESULT,
      ACT_POP,
      ACT_CARVE
   } act_type;

   typedef struct packed {
      act_type act;
      logic    out_free;
      logic    carve_last;
   } dp_status_type;

   typedef struct packed {
      logic load;
      logic commit;
      logic pop;
      logic pop_done;
      logic carve_start;
      logic carve_step;
      logic carve_done;
   } dp_cmd_type;

endpackage

// ----- src/scpa_if.sv -----
// Request and response channel interfaces of the allocator.
interface scpa_req_if import scpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, req_type, request_size, free_address, input ready);
   modport sink   (input valid, req_type, request_size, free_address, output ready);
endinterface

interface scpa_rsp_if import scpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] block_address;
   logic [STAT_W-1:0] status;
   logic [CLS_W-1:0]  size_class;

   modport source (output valid, block_address, status, size_class, input ready);
   modport sink   (input valid, block_address, status, size_class, output ready);
endinterface

// ----- src/scpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module scpa_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, hold data until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- src/scpa_ctrl.sv -----
// Controller state machine of the allocator.
module scpa_ctrl import scpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            case (stat.act)
               ACT_RESULT: if (stat.out_free) state_in = S_IDLE;
               ACT_POP:    state_in = S_READ;
               ACT_CARVE:  state_in = S_CARVE;
               default:    state_in = S_IDLE;
            endcase
         end
         S_READ: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         S_CARVE: begin
            if (stat.carve_last) state_in = S_CFIN;
         end
         S_CFIN: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_EVAL: begin
            cmd.commit      = (stat.act == ACT_RESULT) && stat.out_free;
            cmd.pop         = (stat.act == ACT_POP);
            cmd.carve_start = (stat.act == ACT_CARVE);
         end
         S_READ:  cmd.pop_done   = stat.out_free;
         S_CARVE: cmd.carve_step = 1'b1;
         S_CFIN:  cmd.carve_done = stat.out_free;
         default: cmd = '0;
      endcase
   end
endmodule

// ----- src/scpa_dp.sv -----
// Datapath of the allocator: class state, checks, stack access and result register.
module scpa_dp import scpa_pkg::*; #(
   parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
   parameter int BLOCKS_PER_GROW = DEF_BLOCKS_PER_GROW,
   parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
   parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
   localparam int RAM_AW         = $clog2(NUM_CLASSES * STACK_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   // request payload
   input  logic                 req_type,
   input  logic [SIZE_W-1:0]    request_size,
   input  logic [ADDR_W-1:0]    free_address,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   // result
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    block_address,
   output logic [STAT_W-1:0]    status,
   output logic [CLS_W-1:0]     size_class,
   // stack memory
   output logic                 ram_we,
   output logic [RAM_AW-1:0]    ram_waddr,
   output logic [ADDR_W-1:0]    ram_wdata,
   output logic                 ram_re,
   output logic [RAM_AW-1:0]    ram_raddr,
   input  logic [ADDR_W-1:0]    ram_rdata,
   // control
   input  dp_cmd_type           cmd,
   output dp_status_type        stat
);
   localparam int W        = ADDR_W + 2;
   localparam int CI_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int KW       = $clog2(BLOCKS_PER_GROW + 1);
   localparam int SMALL_MAX = SMALL_BYTES - HEADER_BYTES;
   localparam bit CARVE_FITS = (BLOCKS_PER_GROW <= STACK_DEPTH);
   localparam logic [W-1:0] LIMIT = W'(1) << ADDR_W;
   localparam logic [W-1:0] HDR_W = W'(HEADER_BYTES);

   function automatic logic [RAM_AW-1:0] slot(input logic [CI_W-1:0] c,
                                              input logic [CNT_W-1:0] idx);
      slot = RAM_AW'(c) * RAM_AW'(STACK_DEPTH) + RAM_AW'(idx);
   endfunction

   // configuration and class state
   logic [ADDR_W-1:0] sbase_ff, lbase_ff, limit_ff;
   logic [W-1:0]      ltop_ff;
   logic [W-1:0]      top_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  cnt_ff [NUM_CLASSES];

   // request registers
   logic              type_ff, zero_ff, large_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] hdr_ff;
   logic [CLS_W-1:0]  acls_ff, acls_in;

   // carve sweep
   logic [KW-1:0] k_ff;
   logic [W-1:0]  carve_ff;

   // result register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [STAT_W-1:0] stat_ff;
   logic [CLS_W-1:0]  cls_ff;

   // Size class of an allocate: count thresholds below the size
   always_comb begin
      acls_in = '0;
      for (int i = 0; i < MAX_SIZE_CLASS; i++) begin
         if (((34'(1) << (MIN_BLOCK_SHIFT + i)) - 34'(HEADER_BYTES)) < 34'(request_size))
            acls_in = acls_in + CLS_W'(1);
      end
   end

   // Latch the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         size_ff  <= request_size;
         hdr_ff   <= free_address - ADDR_W'(HEADER_BYTES);
         zero_ff  <= (free_address == '0);
         large_ff <= (request_size > SIZE_W'(SMALL_MAX));
         acls_ff  <= acls_in;
      end
   end

   // Free checks
   logic [W-1:0]      diff;
   logic              in_small, f_bad, f_full, lfree_ok;
   logic [CLS_W-1:0]  fcls;
   logic [CI_W-1:0]   fidx;
   logic [STRIDE_SHIFT-1:0] blk_mask;
   logic [ADDR_W-1:0] ldiff;

   assign diff     = {2'b00, hdr_ff} - {2'b00, sbase_ff};
   assign in_small = (hdr_ff >= sbase_ff)
                     && (diff < (W'(NUM_CLASSES) << STRIDE_SHIFT));
   assign fcls     = diff[STRIDE_SHIFT +: CLS_W];
   assign fidx     = fcls[CI_W-1:0];
   assign blk_mask = (STRIDE_SHIFT'(1) << (MIN_BLOCK_SHIFT + 32'(fcls))) - STRIDE_SHIFT'(1);
   assign f_bad    = ({2'b00, hdr_ff} >= top_ff[fidx])
                     || ((diff[STRIDE_SHIFT-1:0] & blk_mask) != '0);
   assign f_full   = (cnt_ff[fidx] >= CNT_W'(STACK_DEPTH));
   assign ldiff    = hdr_ff - lbase_ff;
   assign lfree_ok = (hdr_ff >= lbase_ff) && ({2'b00, hdr_ff} < ltop_ff)
                     && (ldiff[PAGE_SHIFT-1:0] == '0);

   // Large allocate
   logic [SIZE_W:0] real_size;
   logic [W-1:0]    lsum;
   logic            l_fail;

   assign real_size = ({1'b0, size_ff} + (SIZE_W+1)'((1 << PAGE_SHIFT) - 1))
                      & ~(SIZE_W+1)'((1 << PAGE_SHIFT) - 1);
   assign lsum      = ltop_ff + W'(real_size);
   assign l_fail    = (lsum > {2'b00, limit_ff}) || (lsum > LIMIT);

   // Small allocate
   logic [CI_W-1:0] aidx;
   logic [W-1:0]    a_top, need, gsum, rend, bs;
   logic            a_cls_bad, a_empty, g_fail;

   assign aidx      = acls_ff[CI_W-1:0];
   assign a_cls_bad = (32'(acls_ff) >= NUM_CLASSES);
   assign a_top     = top_ff[aidx];
   assign bs        = W'(1) << (MIN_BLOCK_SHIFT + 32'(acls_ff));
   assign need      = W'(BLOCKS_PER_GROW) << (MIN_BLOCK_SHIFT + 32'(acls_ff));
   assign gsum      = a_top + need;
   assign rend      = {2'b00, sbase_ff} + ((W'(acls_ff) + W'(1)) << STRIDE_SHIFT);
   assign g_fail    = !CARVE_FITS || (gsum > rend) || (gsum > LIMIT);
   assign a_empty   = (cnt_ff[aidx] == '0);

   // Decide the request
   act_type           act;
   logic [ADDR_W-1:0] res_addr;
   logic [STAT_W-1:0] res_stat;
   logic [CLS_W-1:0]  res_cls;
   logic              do_push, do_bump;

   always_comb begin
      act      = ACT_RESULT;
      res_addr = '0;
      res_stat = STAT_OK;
      res_cls  = '0;
      do_push  = 1'b0;
      do_bump  = 1'b0;
      if (type_ff) begin
         if (zero_ff) begin
            res_stat = STAT_OK;
         end else if (in_small) begin
            if (f_bad) begin
               res_stat = STAT_BAD_ADDR;
            end else if (f_full) begin
               res_stat = STAT_OVERFLOW;
               res_cls  = fcls;
            end else begin
               do_push = 1'b1;
               res_cls = fcls;
            end
         end else if (lfree_ok) begin
            res_cls = LARGE_CLASS;
         end else begin
            res_stat = STAT_BAD_ADDR;
         end
      end else if (large_ff) begin
         res_cls = LARGE_CLASS;
         if (l_fail) begin
            res_stat = STAT_OOM;
         end else begin
            do_bump  = 1'b1;
            res_addr = ADDR_W'(ltop_ff + HDR_W);
         end
      end else begin
         res_cls = acls_ff;
         if (a_cls_bad) begin
            res_stat = STAT_OOM;
         end else if (a_empty) begin
            if (g_fail) res_stat = STAT_OOM;
            else        act      = ACT_CARVE;
         end else begin
            act = ACT_POP;
         end
      end
   end

   assign stat.act        = act;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.carve_last = (k_ff == KW'(BLOCKS_PER_GROW - 1));

   // Stack memory ports
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot(aidx, CNT_W'(k_ff));
      ram_wdata = ADDR_W'(carve_ff);
      if (cmd.carve_step) begin
         ram_we = 1'b1;
      end else if (cmd.commit && do_push) begin
         ram_we    = 1'b1;
         ram_waddr = slot(fidx, cnt_ff[fidx]);
         ram_wdata = hdr_ff;
      end
   end

   assign ram_re    = cmd.pop;
   assign ram_raddr = slot(aidx, cnt_ff[aidx] - CNT_W'(1));

   // Class state, configuration and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sbase_ff     <= SMALL_BASE_RST;
         lbase_ff     <= LARGE_BASE_RST;
         limit_ff     <= LARGE_LIMIT_RST;
         ltop_ff      <= W'(LARGE_BASE_RST);
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            top_ff[c] <= W'(SMALL_BASE_RST) + (W'(c) << STRIDE_SHIFT);
            cnt_ff[c] <= '0;
         end
      end else begin
         // drop the result once transferred
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.commit || cmd.pop_done || cmd.carve_done) rsp_valid_ff <= 1'b1;

         if (cmd.commit && do_push) cnt_ff[fidx] <= cnt_ff[fidx] + CNT_W'(1);
         if (cmd.commit && do_bump) ltop_ff <= lsum;
         if (cmd.pop) cnt_ff[aidx] <= cnt_ff[aidx] - CNT_W'(1);
         if (cmd.carve_done) begin
            cnt_ff[aidx] <= CNT_W'(BLOCKS_PER_GROW - 1);
            top_ff[aidx] <= carve_ff;
         end

         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SMALL_BASE: begin
                  sbase_ff <= csr_wdata;
                  for (int c = 0; c < NUM_CLASSES; c++) begin
                     top_ff[c] <= {2'b00, csr_wdata} + (W'(c) << STRIDE_SHIFT);
                     cnt_ff[c] <= '0;
                  end
               end
               CSR_LARGE_BASE: begin
                  lbase_ff <= csr_wdata;
                  ltop_ff  <= {2'b00, csr_wdata};
               end
               CSR_LARGE_LIMIT: limit_ff <= csr_wdata;
               default: limit_ff <= limit_ff;
            endcase
         end
      end
   end

   // Carve sweep: write ascending block addresses
   always_ff @(posedge clock) begin
      if (cmd.carve_start) begin
         k_ff     <= '0;
         carve_ff <= a_top;
      end else if (cmd.carve_step) begin
         k_ff     <= k_ff + KW'(1);
         carve_ff <= carve_ff + bs;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         addr_ff <= res_addr;
         stat_ff <= res_stat;
         cls_ff  <= res_cls;
      end else if (cmd.pop_done) begin
         addr_ff <= ram_rdata + ADDR_W'(HEADER_BYTES);
         stat_ff <= STAT_OK;
         cls_ff  <= acls_ff;
      end else if (cmd.carve_done) begin
         addr_ff <= ADDR_W'(carve_ff - bs + HDR_W);
         stat_ff <= STAT_OK;
         cls_ff  <= acls_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign block_address = addr_ff;
   assign status        = stat_ff;
   assign size_class    = cls_ff;
endmodule

// ----- src/size_class_pool_allocator.sv -----
// Top level of the size-class pool allocator.
//
//  channel  dir  transfer when        payload
//  req      in   req.valid&req.ready  req_type, request_size, free_address
//  rsp      out  rsp.valid&rsp.ready  block_address, status, size_class
//  csr      in   csr_we               csr_index, csr_wdata
//
//  A request is latched and then evaluated; a pop from a free stack adds one
//  read of the stack RAM, and when an empty class is refilled the carve
//  writes one block address per cycle through the single RAM write port.
//  Reset is synchronous; no clearing pass, stacks are tracked by counts. A
//  request is taken while the last result waits; the block stalls only when a
//  new result is ready and the response register is still full.
module size_class_pool_allocator import scpa_pkg::*; #(
   parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
   parameter int BLOCKS_PER_GROW = DEF_BLOCKS_PER_GROW,
   parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
   parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
   input logic                 clock,
   input logic                 reset,
   scpa_req_if.sink            req,
   scpa_rsp_if.source          rsp,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [ADDR_W-1:0]    csr_wdata
);
   localparam int RAM_DEPTH = NUM_CLASSES * STACK_DEPTH;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   dp_cmd_type    cmd;
   dp_status_type stat;

   logic              ram_we, ram_re;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [ADDR_W-1:0] ram_wdata, ram_rdata;

   scpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scpa_dp #(
      .NUM_CLASSES     (NUM_CLASSES),
      .BLOCKS_PER_GROW (BLOCKS_PER_GROW),
      .STACK_DEPTH     (STACK_DEPTH),
      .HEADER_BYTES    (HEADER_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req.req_type),
      .request_size  (req.request_size),
      .free_address  (req.free_address),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .block_address (rsp.block_address),
      .status        (rsp.status),
      .size_class    (rsp.size_class),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .cmd           (cmd),
      .stat          (stat)
   );

   // Free stacks of all classes, one region of STACK_DEPTH entries per class
   scpa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (RAM_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );
endmodule
